// File: sv/cmdp_pkg.sv
// ----------------------------------------------------------------------------
// cmdp_pkg
// Shared constants, types and text helpers of the LED command line parser.
// ----------------------------------------------------------------------------
package cmdp_pkg;

	// line buffer geometry
	localparam int LINE_CAPACITY = 32;
	localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
	localparam int IDX_W         = $clog2(LINE_CAPACITY);

	// results per item never exceed 19, so five bits hold a position
	localparam int POS_W = 5;

	// characters
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_O  = 8'h4f;
	localparam logic [7:0] CH_N  = 8'h4e;

	localparam logic [7:0] BRIGHT_MAX   = 8'd255;
	localparam logic [7:0] BRIGHT_RESET = 8'd255;

	// modes
	localparam logic [1:0] MODE_ON        = 2'd0;
	localparam logic [1:0] MODE_OFF       = 2'd1;
	localparam logic [1:0] MODE_PARITY    = 2'd2;
	localparam logic [1:0] MODE_HEARTBEAT = 2'd3;

	// reply text pieces
	localparam logic [47:0] TXT_PREFIX = "MODE: ";
	localparam int          PREFIX_LEN = 6;

	// decoded line
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_ON,
		CMD_BRIGHT,
		CMD_OFF,
		CMD_PARITY,
		CMD_HEARTBEAT
	} cmd_t;

	// top level control
	typedef enum logic [1:0] {
		TS_IDLE,
		TS_SCAN,
		TS_LAUNCH
	} top_state_t;

	// scan request and response
	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] len;
	} scan_req_t;

	typedef struct packed {
		logic       done;
		cmd_t       cmd;
		logic [7:0] value;
	} scan_rsp_t;

	// launch of one item's transmit run
	typedef struct packed {
		logic       start;
		logic       cr;
		logic [7:0] echo;
		cmd_t       cmd;
		logic [1:0] mode;
		logic [7:0] bright;
	} tx_req_t;

	// command word length; zero for lines that get no reply
	function automatic logic [3:0] word_len(cmd_t c);
		unique case (c)
			CMD_ON:        word_len = 4'd2;
			CMD_OFF:       word_len = 4'd3;
			CMD_PARITY:    word_len = 4'd6;
			CMD_HEARTBEAT: word_len = 4'd9;
			default:       word_len = 4'd0;
		endcase
	endfunction

	// command word, right aligned, first character highest
	function automatic logic [71:0] word_text(cmd_t c);
		unique case (c)
			CMD_ON:        word_text = 72'("ON");
			CMD_OFF:       word_text = 72'("OFF");
			CMD_PARITY:    word_text = 72'("PARITY");
			CMD_HEARTBEAT: word_text = 72'("HEARTBEAT");
			default:       word_text = '0;
		endcase
	endfunction

	// character i of a command word
	function automatic logic [7:0] word_char(cmd_t c, logic [3:0] i);
		logic [71:0] w;
		int          sh;
		w  = word_text(c);
		sh = 8 * (int'(word_len(c)) - 1 - int'(i));
		if (sh < 0) begin
			word_char = '0;
		end else begin
			word_char = 8'(w >> sh);
		end
	endfunction

	// reply length: prefix, word, CR LF
	function automatic logic [POS_W-1:0] reply_len(cmd_t c);
		logic [3:0] wl;
		wl = word_len(c);
		if (wl == 4'd0) begin
			reply_len = '0;
		end else begin
			reply_len = POS_W'(PREFIX_LEN + int'(wl) + 2);
		end
	endfunction

	// character k of a reply
	function automatic logic [7:0] reply_char(cmd_t c, logic [POS_W-1:0] k);
		int wl;
		int kk;
		wl = int'(word_len(c));
		kk = int'(k);
		if (kk < PREFIX_LEN) begin
			reply_char = 8'(TXT_PREFIX >> (8 * (PREFIX_LEN - 1 - kk)));
		end else if (kk < PREFIX_LEN + wl) begin
			reply_char = word_char(c, 4'(kk - PREFIX_LEN));
		end else if (kk == PREFIX_LEN + wl) begin
			reply_char = CH_CR;
		end else begin
			reply_char = CH_LF;
		end
	endfunction

endpackage

// File: sv/cmdp_line_scan.sv
// ----------------------------------------------------------------------------
// cmdp_line_scan
// Line buffer memory and the decoder that walks it one character per cycle.
// ----------------------------------------------------------------------------
module cmdp_line_scan
	import cmdp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [7:0]       wr_data,
	input  scan_req_t        req,
	output scan_rsp_t        rsp
);

	logic [7:0]       mem [LINE_CAPACITY];
	logic [7:0]       rd_data_s1;
	logic             pv_s1;
	logic [IDX_W-1:0] pidx_s1;

	logic             active_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] rd_idx_q;
	logic             on_q, sp_q, dig_q, off_q, par_q, hb_q;
	logic [8:0]       acc_q;

	logic             issue;
	logic [7:0]       digit;
	logic [11:0]      acc_sum;
	logic [8:0]       acc_next;
	logic             is_digit;

	// one read per cycle while indexes remain; writes only happen while idle
	assign issue = active_q && (rd_idx_q != len_q);

	// line buffer memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
		end
		pidx_s1 <= rd_idx_q[IDX_W-1:0];
	end

	// saturating decimal accumulate: acc*10 + digit, clipped at 256
	assign digit    = rd_data_s1 - CH_0;
	assign is_digit = (rd_data_s1 >= CH_0) && (rd_data_s1 <= CH_9);
	assign acc_sum  = {acc_q, 3'b000} + 12'({acc_q, 1'b0}) + {4'b0000, digit};
	assign acc_next = (acc_sum > 12'd255) ? 9'd256 : acc_sum[8:0];

	// scan control and match flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pv_s1    <= 1'b0;
		end else begin
			pv_s1 <= issue;
			if (req.start) begin
				active_q <= 1'b1;
			end else if (active_q && !issue && !pv_s1) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			len_q    <= req.len;
			rd_idx_q <= '0;
			on_q     <= 1'b1;
			sp_q     <= 1'b1;
			dig_q    <= 1'b1;
			off_q    <= 1'b1;
			par_q    <= 1'b1;
			hb_q     <= 1'b1;
			acc_q    <= '0;
		end else begin
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (pv_s1) begin
				if (pidx_s1 == IDX_W'(0) && rd_data_s1 != CH_O) on_q <= 1'b0;
				if (pidx_s1 == IDX_W'(1) && rd_data_s1 != CH_N) on_q <= 1'b0;
				if (pidx_s1 == IDX_W'(2) && rd_data_s1 != CH_SP) sp_q <= 1'b0;
				if (pidx_s1 >= IDX_W'(3)) begin
					if (!is_digit) dig_q <= 1'b0;
					acc_q <= acc_next;
				end
				if (pidx_s1 < IDX_W'(word_len(CMD_OFF)) &&
				    rd_data_s1 != word_char(CMD_OFF, 4'(pidx_s1))) off_q <= 1'b0;
				if (pidx_s1 < IDX_W'(word_len(CMD_PARITY)) &&
				    rd_data_s1 != word_char(CMD_PARITY, 4'(pidx_s1))) par_q <= 1'b0;
				if (pidx_s1 < IDX_W'(word_len(CMD_HEARTBEAT)) &&
				    rd_data_s1 != word_char(CMD_HEARTBEAT, 4'(pidx_s1))) hb_q <= 1'b0;
			end
		end
	end

	// verdict once every character has been looked at
	always_comb begin
		rsp.done  = active_q && !issue && !pv_s1;
		rsp.value = (acc_q > 9'd255) ? BRIGHT_MAX : acc_q[7:0];
		priority if (len_q < LEN_W'(2)) begin
			rsp.cmd = CMD_NONE;
		end else if (on_q) begin
			if (len_q == LEN_W'(2)) begin
				rsp.cmd = CMD_ON;
			end else if (sp_q && dig_q && len_q >= LEN_W'(4)) begin
				rsp.cmd = CMD_BRIGHT;
			end else begin
				rsp.cmd = CMD_NONE;
			end
		end else if (off_q && len_q == LEN_W'(word_len(CMD_OFF))) begin
			rsp.cmd = CMD_OFF;
		end else if (par_q && len_q == LEN_W'(word_len(CMD_PARITY))) begin
			rsp.cmd = CMD_PARITY;
		end else if (hb_q && len_q == LEN_W'(word_len(CMD_HEARTBEAT))) begin
			rsp.cmd = CMD_HEARTBEAT;
		end else begin
			rsp.cmd = CMD_NONE;
		end
	end

	// a new scan is never started on top of a running one
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !active_q)
		else $error("scan restarted while active");

	// reads never run past the line length
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> rd_idx_q <= len_q)
		else $error("scan index past line length");

	// a finished scan goes quiet on the next cycle
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.done && !req.start) |=> !active_q)
		else $error("scan done held");

endmodule

// File: sv/cmdp_tx_seq.sv
// ----------------------------------------------------------------------------
// cmdp_tx_seq
// Emits one item's transmit characters (echo, line feed, reply) through an
// output register, one transfer per cycle while m_axis_tready allows.
// ----------------------------------------------------------------------------
module cmdp_tx_seq
	import cmdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tx_req_t     req,
	output logic        ready,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // tx_byte[7:0], mode[9:8], brightness[17:10], zeros
	output logic        m_axis_tlast
);

	logic             gen_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] last_pos_q;
	logic             cr_q;
	logic [7:0]       echo_q;
	cmd_t             cmd_q;
	logic [1:0]       mode_q;
	logic [7:0]       bright_q;

	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;
	logic [1:0]       out_mode_q;
	logic [7:0]       out_bright_q;

	logic             out_free;
	logic             load;
	logic             at_last;
	logic [7:0]       chr;

	assign ready    = !gen_q;
	assign out_free = !out_valid_q || m_axis_tready;
	assign load     = gen_q && out_free;
	assign at_last  = (pos_q == last_pos_q);

	// character at the current position
	always_comb begin
		priority if (pos_q == POS_W'(0)) begin
			chr = echo_q;
		end else if (cr_q && pos_q == POS_W'(1)) begin
			chr = CH_LF;
		end else begin
			chr = reply_char(cmd_q, pos_q - POS_W'(2));
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.start) begin
				gen_q <= 1'b1;
			end else if (load && at_last) begin
				gen_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item context and output register payload
	always_ff @(posedge clk) begin
		if (req.start) begin
			pos_q      <= '0;
			last_pos_q <= POS_W'({4'b0000, req.cr}) + reply_len(req.cmd);
			cr_q       <= req.cr;
			echo_q     <= req.echo;
			cmd_q      <= req.cmd;
			mode_q     <= req.mode;
			bright_q   <= req.bright;
		end else if (load) begin
			pos_q <= pos_q + 1'b1;
		end
		if (load) begin
			out_data_q   <= chr;
			out_last_q   <= at_last;
			out_mode_q   <= mode_q;
			out_bright_q <= bright_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'b000000, out_bright_q, out_mode_q, out_data_q};

	// launch only into an idle generator
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !gen_q)
		else $error("transmit run launched while busy");

	// position stays inside the run
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gen_q |-> pos_q <= last_pos_q)
		else $error("transmit position past end of run");

	// the final character of a run carries tlast
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(load && at_last) |=> (m_axis_tvalid && m_axis_tlast))
		else $error("final character missing tlast");

endmodule

// File: sv/uart_led_command_parser.sv
// ----------------------------------------------------------------------------
// uart_led_command_parser
// Echoes received characters, collects them into a line and decodes the line
// on carriage return into mode and brightness updates with a text reply.
// ----------------------------------------------------------------------------
//  channel   dir  signals                          carries
//  s_axis    in   tvalid tready tdata[7:0]         rx_byte
//  m_axis    out  tvalid tready tdata[23:0] tlast  tx_byte, mode, brightness;
//                                                  tlast = last
//
//  A plain character is written to the line memory on acceptance and its echo
//  follows once the item is launched and has passed the output register. A
//  carriage return scans the line memory one entry a cycle, then sends up to
//  19 transfers, one a cycle while m_axis is ready. A new item is taken once
//  the previous item's run has been launched into the transmit sequencer.
//  m_axis stalls hold the run; reset clears line, mode 0, brightness 255.
// ----------------------------------------------------------------------------
module uart_led_command_parser
	import cmdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // tx_byte[7:0], mode[9:8], brightness[17:10], zeros
	output logic        m_axis_tlast
);

	top_state_t       state_q, state_d;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [1:0]       mode_q;
	logic [7:0]       bright_q;
	logic             cr_q;
	logic [7:0]       echo_q;
	cmd_t             cmd_q;
	logic [7:0]       val_q;

	logic             accept;
	logic             is_cr;
	logic             room;
	logic             launch;
	logic             tx_ready;
	logic [1:0]       mode_d;
	logic [7:0]       bright_d;
	scan_req_t        scan_req;
	scan_rsp_t        scan_rsp;
	tx_req_t          tx_req;

	assign s_axis_tready = (state_q == TS_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_cr         = (s_axis_tdata == CH_CR);
	assign room          = (len_q < LEN_W'(LINE_CAPACITY));
	assign launch        = (state_q == TS_LAUNCH) && tx_ready;

	assign scan_req.start = accept && is_cr && !ovf_q;
	assign scan_req.len   = len_q;

	// line memory and decoder
	cmdp_line_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && !is_cr && room),
		.wr_addr (len_q[IDX_W-1:0]),
		.wr_data (s_axis_tdata),
		.req     (scan_req),
		.rsp     (scan_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE: begin
				if (scan_req.start) begin
					state_d = TS_SCAN;
				end else if (accept) begin
					state_d = TS_LAUNCH;
				end
			end
			TS_SCAN: begin
				if (scan_rsp.done) state_d = TS_LAUNCH;
			end
			TS_LAUNCH: begin
				if (tx_ready) state_d = TS_IDLE;
			end
			default: state_d = TS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// mode and brightness after the decoded line
	always_comb begin
		mode_d   = mode_q;
		bright_d = bright_q;
		unique case (cmd_q)
			CMD_ON: begin
				mode_d   = MODE_ON;
				bright_d = BRIGHT_MAX;
			end
			CMD_BRIGHT:    bright_d = val_q;
			CMD_OFF:       mode_d = MODE_OFF;
			CMD_PARITY:    mode_d = MODE_PARITY;
			CMD_HEARTBEAT: mode_d = MODE_HEARTBEAT;
			default: ;
		endcase
	end

	// line bookkeeping and settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			mode_q   <= MODE_ON;
			bright_q <= BRIGHT_RESET;
		end else begin
			if (accept) begin
				if (is_cr) begin
					len_q <= '0;
					ovf_q <= 1'b0;
				end else if (room) begin
					len_q <= len_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (launch) begin
				mode_q   <= mode_d;
				bright_q <= bright_d;
			end
		end
	end

	// item context for the transmit run
	always_ff @(posedge clk) begin
		if (accept) begin
			cr_q   <= is_cr;
			echo_q <= s_axis_tdata;
			cmd_q  <= CMD_NONE;
		end else if (state_q == TS_SCAN && scan_rsp.done) begin
			cmd_q <= scan_rsp.cmd;
			val_q <= scan_rsp.value;
		end
	end

	assign tx_req.start  = launch;
	assign tx_req.cr     = cr_q;
	assign tx_req.echo   = echo_q;
	assign tx_req.cmd    = cmd_q;
	assign tx_req.mode   = mode_d;
	assign tx_req.bright = bright_d;

	// transmit sequencer and output register
	cmdp_tx_seq u_tx (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (tx_req),
		.ready         (tx_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// overflow only ever follows a full line
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LEN_W'(LINE_CAPACITY))
		else $error("overflow without full line");

	// decoder answers only while waiting for it
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_rsp.done |-> state_q == TS_SCAN)
		else $error("scan finished outside scan state");

	// carriage return leaves an empty line behind
	a_cr_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_cr) |=> (len_q == '0 && !ovf_q))
		else $error("line not cleared after carriage return");

endmodule

// File: verif/uart_led_command_parser_chk.sv
// ----------------------------------------------------------------------------
// uart_led_command_parser_chk
// Watches both streams of the command line parser. It keeps its own copy of
// the line buffer, mode and brightness, works out the transmit run of every
// accepted character and compares each output transfer with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module uart_led_command_parser_chk
	import cmdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // rx_byte[7:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,    // tx_byte[7:0], mode[9:8], brightness[17:10], zeros
	input  logic        m_tlast,
	input  logic        end_check,
	output int          fail_count,
	output int          pending,
	output int          xfers_seen
);

	// one expected output transfer
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
		logic [1:0] mode;
		logic [7:0] brightness;
	} tx_xfer_t;

	tx_xfer_t    tx_expect_q[$];

	// shadow of the parser state
	logic [7:0]  line_mem [LINE_CAPACITY];
	int unsigned line_len;
	bit          line_ovf;
	logic [1:0]  cur_mode;
	logic [7:0]  cur_bright;
	bit          leftovers_done;

	// whole line equals a command word
	function automatic bit line_is(string word);
		if (line_len != word.len()) return 0;
		for (int i = 0; i < word.len(); i++) begin
			if (line_mem[i] != word[i]) return 0;
		end
		return 1;
	endfunction

	// decode the held line, update mode/brightness, return the reply word
	function automatic string apply_line();
		int unsigned acc;
		if (line_len < 2) return "";
		if (line_mem[0] == CH_O && line_mem[1] == CH_N) begin
			if (line_len == 2) begin
				cur_bright = BRIGHT_MAX;
				cur_mode   = MODE_ON;
				return "ON";
			end
			if (line_mem[2] != CH_SP || line_len < 4) return "";
			acc = 0;
			for (int i = 3; i < line_len; i++) begin
				if (line_mem[i] < CH_0 || line_mem[i] > CH_9) return "";
				acc = acc * 10 + 32'(line_mem[i] - CH_0);
				// clamp early so long digit strings never wrap
				if (acc > 255) acc = 256;
			end
			cur_bright = (acc > 255) ? BRIGHT_MAX : acc[7:0];
			return "";
		end
		if (line_is("OFF")) begin
			cur_mode = MODE_OFF;
			return "OFF";
		end
		if (line_is("PARITY")) begin
			cur_mode = MODE_PARITY;
			return "PARITY";
		end
		if (line_is("HEARTBEAT")) begin
			cur_mode = MODE_HEARTBEAT;
			return "HEARTBEAT";
		end
		return "";
	endfunction

	// expected transmit run for one received character
	function automatic void predict_char(logic [7:0] c);
		logic [7:0] tx[$];
		string      word;
		tx_xfer_t   x;
		tx.push_back(c);
		if (c == CH_CR) begin
			tx.push_back(CH_LF);
			// an overflowed line is dropped without decode
			if (!line_ovf) begin
				word = apply_line();
				if (word.len() != 0) begin
					word = {"MODE: ", word};
					for (int i = 0; i < word.len(); i++) tx.push_back(word[i]);
					tx.push_back(CH_CR);
					tx.push_back(CH_LF);
				end
			end
			line_len = 0;
			line_ovf = 0;
		end else if (line_len < LINE_CAPACITY) begin
			line_mem[line_len] = c;
			line_len++;
		end else begin
			line_ovf = 1;
		end
		foreach (tx[k]) begin
			x.tx_byte    = tx[k];
			x.last       = (k == tx.size() - 1);
			x.mode       = cur_mode;
			x.brightness = cur_bright;
			tx_expect_q.push_back(x);
		end
	endfunction

	// compare one output transfer with the oldest expectation
	function automatic void check_xfer();
		tx_xfer_t got;
		tx_xfer_t exp;
		got = {m_tdata[7:0], m_tlast, m_tdata[9:8], m_tdata[17:10]};
		xfers_seen++;
		if (tx_expect_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: unexpected transfer tx=%02h last=%0d mode=%0d bright=%0d",
					$time, got.tx_byte, got.last, got.mode, got.brightness);
			return;
		end
		exp = tx_expect_q.pop_front();
		if (got !== exp || m_tdata[23:18] !== 6'd0) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: mismatch exp tx=%02h last=%0d mode=%0d bright=%0d",
					$time, exp.tx_byte, exp.last, exp.mode, exp.brightness);
				$display("%0t:          got tx=%02h last=%0d mode=%0d bright=%0d pad=%02h",
					$time, got.tx_byte, got.last, got.mode, got.brightness,
					m_tdata[23:18]);
			end
		end
	endfunction

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (line_mem[i]) line_mem[i] = '0;
			line_len       = 0;
			line_ovf       = 0;
			cur_mode       = MODE_ON;
			cur_bright     = BRIGHT_RESET;
			tx_expect_q.delete();
			fail_count     = 0;
			pending        = 0;
			xfers_seen     = 0;
			leftovers_done = 0;
		end else begin
			if (s_tvalid && s_tready) predict_char(s_tdata);
			if (m_tvalid && m_tready) check_xfer();
			// anything still outstanding at the end is missing output
			if (end_check && !leftovers_done) begin
				leftovers_done = 1;
				if (tx_expect_q.size() != 0) begin
					fail_count += tx_expect_q.size();
					$display("%0t: %0d expected transfers never arrived",
						$time, tx_expect_q.size());
				end
			end
			pending = tx_expect_q.size();
		end
	end

endmodule

// File: verif/uart_led_command_parser_tb.sv
// ----------------------------------------------------------------------------
// uart_led_command_parser_tb
// Feeds command lines into the parser: a directed set covering every command,
// brightness saturation, malformed and empty lines, zero bytes and buffer
// overflow, then random lines under three idle profiles and one long output
// stall. The checker beside the block predicts and compares every transfer.
// ----------------------------------------------------------------------------
module uart_led_command_parser_tb;
	import cmdp_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int RAND_CHARS   = 170;
	localparam int HOLD_CYCLES  = 400;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	logic        end_check;
	int          fail_count;
	int          pending;
	int          xfers_seen;

	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          rx_hold;
	int          phase;
	int          chars_sent;
	int          lines_sent;
	int          cycle_cnt;
	logic [7:0]  line_q[$];
	string       cmd_words[4] = '{"ON", "OFF", "PARITY", "HEARTBEAT"};

	uart_led_command_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	uart_led_command_parser_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tlast    (m_axis_tlast),
		.end_check  (end_check),
		.fail_count (fail_count),
		.pending    (pending),
		.xfers_seen (xfers_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// output side backpressure
	initial m_axis_tready = 1'b0;
	always @(negedge clk) begin
		m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// long output stall while input keeps coming, counted on its own
	initial begin
		rx_hold = 1'b0;
		wait (phase == 2);
		repeat (40) @(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// one character transfer, entered and left at a falling edge
	task automatic send_char(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		// tready only moves at the rising edge, so look at it mid-cycle
		while (!s_axis_tready) @(negedge clk);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
	endtask

	// terminate the pending line with CR and send it
	task automatic flush_line();
		line_q.push_back(CH_CR);
		foreach (line_q[i]) send_char(line_q[i]);
		line_q.delete();
		lines_sent++;
	endtask

	task automatic add_digits(input int n, input logic [7:0] d);
		repeat (n) line_q.push_back(d);
	endtask

	// sender pauses until every expected transfer has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	function automatic logic [7:0] non_cr_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		return (b == CH_CR) ? 8'hff : b;
	endfunction

	function automatic logic [7:0] non_digit_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		return (b == CH_CR || (b >= CH_0 && b <= CH_9)) ? 8'h78 : b;
	endfunction

	// random line, mostly well formed commands with random content
	task automatic random_line();
		int    kind;
		int    n;
		int    pos;
		string w;
		kind = $urandom_range(99);
		w    = cmd_words[$urandom_range(3)];
		if (kind < 40) begin
			add_text(w);
		end else if (kind < 65) begin
			add_text("ON ");
			n = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
			repeat (n) line_q.push_back(CH_0 + 8'($urandom_range(9)));
		end else if (kind < 78) begin
			// near misses of a command
			case ($urandom_range(3))
				0: add_text(w.substr(0, w.len() - 2));
				1: begin
					add_text(w);
					line_q.push_back(non_cr_byte());
				end
				2: begin
					pos = $urandom_range(w.len() - 1);
					for (int i = 0; i < w.len(); i++)
						line_q.push_back((i == pos) ? non_cr_byte() : w[i]);
				end
				default: begin
					add_text("ON ");
					line_q.push_back(CH_0 + 8'($urandom_range(9)));
					line_q.push_back(non_digit_byte());
					line_q.push_back(CH_0 + 8'($urandom_range(9)));
				end
			endcase
		end else if (kind < 88) begin
			// raw bytes over the full range
			n = $urandom_range(10);
			repeat (n) line_q.push_back(8'($urandom_range(255)));
		end else if (kind < 94) begin
			// brightness lines around the buffer capacity
			add_text("ON ");
			n = $urandom_range(LINE_CAPACITY - 4, LINE_CAPACITY + 2);
			repeat (n) line_q.push_back(CH_0 + 8'($urandom_range(9)));
		end else begin
			case ($urandom_range(2))
				0: ;
				1: add_text("ON ");
				default: add_text("ON");
			endcase
		end
		flush_line();
	endtask

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		end_check     = 1'b0;
		tx_idle_pct   = 22;
		rx_idle_pct   = 80;
		phase         = 0;
		chars_sent    = 0;
		lines_sent    = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every command, saturation, malformed, empty, zero byte and overflow
		add_text("ON 0");      flush_line();
		add_text("OFF");       flush_line();
		add_text("PARITY");    flush_line();
		add_text("HEARTBEAT"); flush_line();
		add_text("ON 99999");  flush_line();
		add_text("ON 007");    flush_line();
		add_text("ON");        flush_line();
		flush_line();
		add_text("ON ");       flush_line();
		add_text("ON 1x");     flush_line();
		add_text("OFF");
		line_q.push_back(8'h00);
		flush_line();
		line_q.push_back(8'hff);
		line_q.push_back(8'h00);
		line_q.push_back(8'h80);
		line_q.push_back(8'h7f);
		flush_line();
		// exactly full line still decodes, one more character drops it
		add_text("ON ");
		add_digits(LINE_CAPACITY - 4, CH_0);
		line_q.push_back(CH_0 + 8'd5);
		flush_line();
		add_text("ON ");
		add_digits(LINE_CAPACITY - 3, CH_0);
		line_q.push_back(CH_9);
		flush_line();
		add_text("PARITY");    flush_line();

		// random lines over three idle profiles
		n_loop: begin
			int base;
			base = chars_sent;
			while (chars_sent < base + RAND_CHARS) begin
				random_line();
				if (phase == 0 && chars_sent >= base + RAND_CHARS / 3) begin
					drain();
					tx_idle_pct = 80;
					rx_idle_pct = 22;
					phase       = 1;
				end else if (phase == 1 && chars_sent >= base + 2 * RAND_CHARS / 3) begin
					drain();
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					phase       = 2;
				end
			end
		end

		// wait out the last runs, then the parser's own latency
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		end_check = 1'b1;
		@(negedge clk);

		$display("Sent %0d characters in %0d lines, %0d transmit transfers checked",
			chars_sent, lines_sent, xfers_seen);
		$display("Profiles: slow output, slow input, full rate with a %0d-cycle output stall",
			HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/cmdp_pkg.sv
sv/cmdp_line_scan.sv
sv/cmdp_tx_seq.sv
sv/uart_led_command_parser.sv
verif/uart_led_command_parser_chk.sv
verif/uart_led_command_parser_tb.sv
